### rtl/assert_macros.svh
// Assertion macros used by the checker in rafu_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define RAFU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds through reset.
`define RAFU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### rtl/rafu_pkg.sv
`default_nettype none
package rafu_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = PTR_W + 1;
  localparam int SAMPLE_W   = 32;
  localparam int SUM_W      = SAMPLE_W + PTR_W;
  localparam int DIVCNT_W   = $clog2(SUM_W + 1);

  localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(20);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } rafu_state_t;

endpackage
`default_nettype wire

### rtl/rafu_if.sv
`default_nettype none
interface rafu_smp_if;
  import rafu_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rafu_avg_if;
  import rafu_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] average;
  modport source (output valid, output average, input ready);
  modport sink (input valid, input average, output ready);
endinterface
`default_nettype wire

### rtl/rafu_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module rafu_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rafu_pkg::SUM_W-1:0] dividend,
  input  wire logic [rafu_pkg::CNT_W-1:0] divisor,
  output logic                            done,
  output logic [rafu_pkg::SUM_W-1:0]      quotient
);
  import rafu_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [DIVCNT_W-1:0] cnt_r;
  logic [SUM_W-1:0]    dvd_r;
  logic [CNT_W-1:0]    rem_r;
  logic [CNT_W-1:0]    dvs_r;

  logic [CNT_W:0]      trial;
  logic                qbit;
  logic [CNT_W-1:0]    rem_nxt;
  logic [CNT_W:0]      diff;

  always_comb begin
    trial   = {rem_r, dvd_r[SUM_W-1]};
    diff    = trial - {1'b0, dvs_r};
    qbit    = (trial >= {1'b0, dvs_r});
    rem_nxt = qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == DIVCNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= DIVCNT_W'(SUM_W);
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r - DIVCNT_W'(1);
      dvd_r <= {dvd_r[SUM_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule
`default_nettype wire

### rtl/running_average_filter_unit.sv
`default_nettype none
// Sequence per sample: take beat, accumulate, 37 divider steps, done, load out;
// out_avg.valid is registered from the load. The block takes no new sample beat
// until the previous average has been loaded into the output register.
// A stalled average holds the sequencer in its output state until the beat is taken.
// Reset (rst_n low at a clock edge, synchronous) empties the sample ring, clears
// sum, pointer and fill count, drops any pending beat and loads window length 20.
module running_average_filter_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  rafu_smp_if.sink                        in_smp,
  rafu_avg_if.source                      out_avg,
  input  wire logic                       cfg_we,
  input  wire logic [rafu_pkg::CNT_W-1:0] cfg_wdata
);
  import rafu_pkg::*;

  // State and control
  rafu_state_t state_r, state_nxt;

  logic [CNT_W-1:0]    win_r;
  logic [CNT_W-1:0]    len_eff;
  logic [PTR_W-1:0]    wp_r;
  logic [CNT_W-1:0]    fill_r;
  logic [CNT_W-1:0]    fill_nxt;
  logic [CNT_W-1:0]    wp_inc;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;

  // Sample ring with one valid bit per slot; an empty slot reads as zero.
  logic [SAMPLE_W-1:0] mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] vld_r;
  logic [SAMPLE_W-1:0] rd_r;
  logic                rd_vld_r;
  logic signed [SAMPLE_W-1:0] old_smp;
  logic signed [SAMPLE_W-1:0] smp_r;

  logic                neg_r;
  logic [SUM_W-1:0]    mag;
  logic                div_start;
  logic                div_done;
  logic [SUM_W-1:0]    quot;

  logic                in_acc;
  logic                out_load;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_avg_r;
  logic [SAMPLE_W-1:0] avg_sat;

  assign in_acc = in_smp.valid && in_smp.ready;

  // Clamp window: zero acts as one, above ring depth saturates.
  always_comb begin
    len_eff = win_r;
    if (win_r == '0) begin
      len_eff = CNT_W'(1);
    end else if (win_r > CNT_W'(MAX_WINDOW)) begin
      len_eff = CNT_W'(MAX_WINDOW);
    end
  end

  // Window length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WINDOW_RESET;
    end else if (cfg_we) begin
      win_r <= cfg_wdata;
    end
  end

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_ACC;
      end
      ST_ACC:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_avg.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output decode
  always_comb begin
    in_smp.ready = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE: in_smp.ready = 1'b1;
      ST_ACC:  div_start    = 1'b1;
      ST_DIV:  ;
      ST_OUT:  out_load     = !out_valid_r || out_avg.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Update sum: drop oldest slot value, add new sample.
  assign old_smp = rd_vld_r ? rd_r : '0;
  assign wp_inc  = {1'b0, wp_r} + CNT_W'(1);

  always_comb begin
    sum_nxt  = sum_r - SUM_W'(old_smp) + SUM_W'(smp_r);
    fill_nxt = (fill_r < len_eff) ? fill_r + CNT_W'(1) : fill_r;
    mag      = sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);
  end

  // Ring read on accept, write back in the accumulate cycle.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r  <= mem[wp_r];
      smp_r <= in_smp.sample;
    end
    if (state_r == ST_ACC) begin
      mem[wp_r] <= smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      wp_r     <= '0;
      fill_r   <= '0;
      sum_r    <= '0;
      neg_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        rd_vld_r <= vld_r[wp_r];
      end
      if (state_r == ST_ACC) begin
        vld_r[wp_r] <= 1'b1;
        sum_r       <= sum_nxt;
        fill_r      <= fill_nxt;
        neg_r       <= sum_nxt[SUM_W-1];
        // Wrap pointer at the effective window length.
        wp_r        <= (wp_inc >= len_eff) ? '0 : wp_inc[PTR_W-1:0];
      end
    end
  end

  rafu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag),
    .divisor  (fill_nxt),
    .done     (div_done),
    .quotient (quot)
  );

  // Restore sign and saturate to the 32-bit range.
  always_comb begin
    if (!neg_r) begin
      if (quot > SUM_W'({1'b0, {(SAMPLE_W-1){1'b1}}})) begin
        avg_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
        avg_sat = quot[SAMPLE_W-1:0];
      end
    end else begin
      if (quot >= SUM_W'({1'b1, {(SAMPLE_W-1){1'b0}}})) begin
        avg_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
        avg_sat = -quot[SAMPLE_W-1:0];
      end
    end
  end

  // Output register: hold the beat until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_avg.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_avg_r <= avg_sat;
    end
  end

  assign out_avg.valid   = out_valid_r;
  assign out_avg.average = out_avg_r;

endmodule
`default_nettype wire

### rtl/rafu_checker.sv
`default_nettype none
`include "assert_macros.svh"
module rafu_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [rafu_pkg::SAMPLE_W-1:0] out_average
);
  import rafu_pkg::*;

  `RAFU_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `RAFU_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_average))
  `RAFU_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready)
  `RAFU_ASSERT(a_idle_on_result, clk, rst_n, $rose(out_valid) |-> in_ready)
  `RAFU_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid)

endmodule

bind running_average_filter_unit rafu_checker u_rafu_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_smp.valid),
  .in_ready    (in_smp.ready),
  .out_valid   (out_avg.valid),
  .out_ready   (out_avg.ready),
  .out_average (out_avg.average)
);
`default_nettype wire

### tb/rafu_avg_checker.sv
`default_nettype none
module rafu_avg_checker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                smp_valid,
  input  wire logic                                smp_ready,
  input  wire logic signed [rafu_pkg::SAMPLE_W-1:0] smp_sample,
  input  wire logic                                avg_valid,
  input  wire logic                                avg_ready,
  input  wire logic signed [rafu_pkg::SAMPLE_W-1:0] avg_average,
  input  wire logic                                cfg_we,
  input  wire logic [rafu_pkg::CNT_W-1:0]          cfg_wdata,
  output int                                       mismatch_count,
  output int                                       averages_due
);
  import rafu_pkg::*;

  logic signed [SAMPLE_W-1:0] ring [MAX_WINDOW];
  logic [PTR_W-1:0]           wr_slot;
  logic [CNT_W-1:0]           filled;
  logic signed [SUM_W-1:0]    ring_total;
  logic [CNT_W-1:0]           window_reg;
  logic signed [SAMPLE_W-1:0] pending_averages [$];
  int                         misses = 0;

  assign mismatch_count = misses;

  // Clamp the register to the usable window: zero acts as one, large values saturate.
  function automatic int active_window();
    if (window_reg == 0) return 1;
    if (window_reg > MAX_WINDOW) return MAX_WINDOW;
    return int'(window_reg);
  endfunction

  // Fold one sample into the ring and return the mean it produces.
  function automatic logic signed [SAMPLE_W-1:0] next_average(
    input logic signed [SAMPLE_W-1:0] s);
    int                      len;
    int                      slot;
    logic signed [SUM_W-1:0] quot;
    longint                  wide;
    len  = active_window();
    slot = int'(wr_slot);
    if (slot >= MAX_WINDOW) slot = 0;
    ring_total = ring_total - ring[slot] + s;
    ring[slot] = s;
    wr_slot    = (slot + 1 >= len) ? '0 : PTR_W'(slot + 1);
    if (int'(filled) < len) filled = filled + 1'b1;
    quot = ring_total / $signed({1'b0, filled});
    wide = longint'(quot);
    if (wide > 64'sd2147483647) wide = 64'sd2147483647;
    if (wide < -64'sd2147483648) wide = -64'sd2147483648;
    return SAMPLE_W'(wide);
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      foreach (ring[i]) ring[i] = '0;
      wr_slot    = '0;
      filled     = '0;
      ring_total = '0;
      window_reg = WINDOW_RESET;
      pending_averages.delete();
    end else begin
      if (cfg_we) window_reg = cfg_wdata;
      if (smp_valid && smp_ready) pending_averages.push_back(next_average(smp_sample));
      if (avg_valid && avg_ready) begin
        if (pending_averages.size() == 0) begin
          $error("average: expected none, actual %0d", avg_average);
          misses++;
        end else begin
          want = pending_averages.pop_front();
          if (avg_average !== want) begin
            $error("average: expected %0d, actual %0d", want, avg_average);
            misses++;
          end
        end
      end
    end
    averages_due <= pending_averages.size();
  end

endmodule
`default_nettype wire

### tb/running_average_filter_unit_tb.sv
`default_nettype none
module running_average_filter_unit_tb;
  import rafu_pkg::*;

  // Stop when no beat moves on either channel for this many cycles.
  localparam int QUIET_LIMIT  = 1000;
  // Settle time after the last average, a bit above the block latency.
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 1500;

  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 32'sh7fffffff;
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 32'sh80000000;

  // Receiver behavior on the average channel.
  typedef enum int {
    RX_ALWAYS,  // ready every cycle
    RX_COIN,    // ready on a coin flip each cycle
    RX_LONG     // long stretches of ready and stalled
  } rx_mode_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  rafu_smp_if smp ();
  rafu_avg_if avg ();

  int       mismatches;
  int       due;
  int       quiet_cycles = 0;
  int       burst_left   = 0;
  int       sent         = 0;
  bit       gaps_on      = 1'b0;
  rx_mode_t rx_mode      = RX_ALWAYS;

  running_average_filter_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_smp    (smp),
    .out_avg   (avg),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Watch both channels and the register port; predict and compare each average.
  rafu_avg_checker u_avg_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .smp_valid      (smp.valid),
    .smp_ready      (smp.ready),
    .smp_sample     (smp.sample),
    .avg_valid      (avg.valid),
    .avg_ready      (avg.ready),
    .avg_average    (avg.average),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatches),
    .averages_due   (due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: hold ready for a run of cycles, then pick the next run by mode.
  initial begin
    int run;
    bit hold;
    run  = 0;
    hold = 1'b0;
    avg.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (run == 0) begin
        case (rx_mode)
          RX_ALWAYS: begin
            hold = 1'b1;
            run  = 1;
          end
          RX_COIN: begin
            hold = $urandom_range(0, 1);
            run  = 1;
          end
          default: begin
            hold = ~hold;
            run  = $urandom_range(1, 20);
          end
        endcase
      end
      avg.ready <= hold;
      run--;
    end
  end

  // Watchdog: count cycles without any beat; give up at the limit.
  always @(posedge clk) begin
    if (!rst_n || (smp.valid && smp.ready) || (avg.valid && avg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Offer one sample beat and hold it until taken. When gaps are on, drop valid
  // for a random gap between bursts.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] v);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 50) : $urandom_range(1, 12);
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    smp.valid  <= 1'b1;
    smp.sample <= v;
    do @(posedge clk); while (!smp.ready);
    if (burst_left > 0) burst_left--;
  endtask

  // Drop valid and wait until every predicted average has come back.
  task automatic wait_idle();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (due != 0) @(posedge clk);
  endtask

  // Change the window only once the block has gone idle.
  task automatic write_window(input logic [CNT_W-1:0] w);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mix extremes, values near the limits, small values and fully random words.
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return $signed($urandom_range(0, 2)) - 1;
      3, 4:    return $signed($urandom_range(0, 2000)) - 1000;
      5:       return SMP_MAX - $signed($urandom_range(0, 255));
      6:       return SMP_MIN + $signed($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  // Favor the edges of the window register: zero, one, two, full, past full, all ones.
  function automatic logic [CNT_W-1:0] pick_window();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CNT_W'(1);
      2:       return CNT_W'(MAX_WINDOW);
      3:       return '1;
      4:       return ($urandom_range(0, 1) != 0) ? CNT_W'(MAX_WINDOW + 1) : CNT_W'(2);
      default: return CNT_W'($urandom_range(0, 63));
    endcase
  endfunction

  initial begin
    int phase_len;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    smp.valid  <= 1'b0;
    smp.sample <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset window of 20, full-scale samples of both signs.
    push_sample('0);
    push_sample(SMP_MAX);
    push_sample(SMP_MIN);
    push_sample(SMP_MAX);
    push_sample(SMP_MAX);
    push_sample(-1);
    push_sample(1);
    push_sample(SMP_MIN);

    // Shrink to one while the pointer sits past the new end; it must wrap.
    write_window(CNT_W'(1));
    push_sample(5);
    push_sample(-5);

    // Zero acts as a window of one.
    write_window('0);
    push_sample(SMP_MIN);
    push_sample(SMP_MAX);

    // All ones saturates to the largest window.
    write_window('1);
    push_sample(SMP_MAX);
    push_sample(-7);
    push_sample(SMP_MIN);

    write_window(CNT_W'(MAX_WINDOW));
    push_sample(SMP_MIN);
    push_sample(3);

    // Grow then shrink to two with the pointer beyond the last slot.
    write_window(CNT_W'(2));
    push_sample(SMP_MAX);
    push_sample(SMP_MAX);
    push_sample(-3);

    // Random phases: new window most of the time, new idling pattern each phase.
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(10, 120);
      if ($urandom_range(0, 3) != 0) write_window(pick_window());
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0:       rx_mode = RX_ALWAYS;
        1:       rx_mode = RX_COIN;
        default: rx_mode = RX_LONG;
      endcase
      repeat (phase_len) push_sample(rand_sample());
      sent += phase_len;
    end

    // Drain every average, then let the block settle before the verdict.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
